// ----- rtl/smf_track_event_encoder_defines.svh -----
// Assertion macros shared by the track event encoder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SMF_TRACK_EVENT_ENCODER_DEFINES_SVH
`define SMF_TRACK_EVENT_ENCODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smf encoder: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smf encoder: next-cycle check failed");

`endif

// ----- rtl/smfenc_pkg.sv -----
// Types, codes and helpers for the SMF track event encoder.
// Depends on nothing; used by smfenc_expand and smf_track_event_encoder.
package smfenc_pkg;

  // Request codes; the fourth code is ignored by the block.
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_HEADER = 2'd1;
  localparam logic [1:0] REQ_DATA   = 2'd2;

  // Event kinds.
  localparam logic [1:0] KIND_CHANNEL = 2'd0;
  localparam logic [1:0] KIND_META    = 2'd1;
  localparam logic [1:0] KIND_SYSEX   = 2'd2;
  localparam logic [1:0] KIND_ESCAPE  = 2'd3;

  localparam logic [7:0] TYPE_META   = 8'hFF;
  localparam logic [7:0] TYPE_SYSEX  = 8'hF0;
  localparam logic [7:0] TYPE_ESCAPE = 8'hF7;

  localparam int MaxBytes = 10;
  localparam int CountW   = $clog2(MaxBytes + 1);

  typedef logic [MaxBytes-1:0][7:0] byte_list_t;
  typedef logic [CountW-1:0]        byte_count_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] tick;
    logic [1:0]  kind;
    logic [7:0]  meta_type;
    logic [27:0] event_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  running_status;
    logic [31:0] previous_tick;
    logic [1:0]  current_kind;
    logic        expect_first_byte;
  } enc_state_t;

  localparam enc_state_t STATE_RESET = '{
    running_status:    8'h00,
    previous_tick:     32'h0,
    current_kind:      KIND_CHANNEL,
    expect_first_byte: 1'b0
  };

  // A variable-length quantity of up to 28 bits, first byte in bytes[0].
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
  } vlq_t;

  function automatic vlq_t vlq_encode(input logic [27:0] v);
    vlq_t r;
    r.count = 3'd1 + 3'(v[27:7] != '0) + 3'(v[27:14] != '0) + 3'(v[27:21] != '0);
    r.bytes = '0;
    case (r.count)
      3'd1: begin
        r.bytes[0] = {1'b0, v[6:0]};
      end
      3'd2: begin
        r.bytes[0] = {1'b1, v[13:7]};
        r.bytes[1] = {1'b0, v[6:0]};
      end
      3'd3: begin
        r.bytes[0] = {1'b1, v[20:14]};
        r.bytes[1] = {1'b1, v[13:7]};
        r.bytes[2] = {1'b0, v[6:0]};
      end
      default: begin
        r.bytes[0] = {1'b1, v[27:21]};
        r.bytes[1] = {1'b1, v[20:14]};
        r.bytes[2] = {1'b1, v[13:7]};
        r.bytes[3] = {1'b0, v[6:0]};
      end
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/smf_track_event_encoder.sv -----
// Top level of the SMF track event encoder: input register, expander, byte queue.
// Depends on smfenc_pkg, smfenc_expand and smf_track_event_encoder_defines.svh.
//
// Input channel (in_valid/in_ready/in_item) takes one request per beat: track
// start, event header or event data byte. Output channel (out_valid/out_ready/
// out_item) delivers the encoded track stream one byte per beat, with last set
// on the final byte that a request produces. Requests that produce no bytes
// (track start, a repeated channel status byte, the unused code) leave no trace
// on the output.
// A request is held in the input register, then expanded in a single pass into
// up to ten bytes that load a byte queue, which offers the first of them. The
// load waits until the queue is empty or its last byte leaves. The queue drains
// one byte per cycle while the receiver takes them; a data byte makes one byte,
// a header one to ten. While the receiver is ready, a new request loads in the
// cycle the queue's last byte leaves, so data bytes stream at one per cycle
// without gaps. When the receiver stalls, the queue holds, one request waits in
// the input register and in_ready falls. Synchronous reset empties both, clears
// the running status, previous tick and status-byte expectation.
`include "smf_track_event_encoder_defines.svh"

module smf_track_event_encoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  smfenc_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output smfenc_pkg::out_item_t out_item
);

  logic                    s1_valid;
  smfenc_pkg::in_item_t    s1_item;
  smfenc_pkg::enc_state_t  state;
  smfenc_pkg::enc_state_t  state_next;
  smfenc_pkg::byte_list_t  exp_bytes;
  smfenc_pkg::byte_count_t exp_count;
  smfenc_pkg::byte_list_t  queue;
  smfenc_pkg::byte_count_t count;
  logic                    pop;
  logic                    queue_free;
  logic                    load;

  smfenc_expand u_expand (
    .item       (s1_item),
    .state      (state),
    .bytes      (exp_bytes),
    .count      (exp_count),
    .state_next (state_next)
  );

  assign out_valid  = (count != '0);
  assign pop        = out_valid && out_ready;
  assign queue_free = (count == '0) || (count == smfenc_pkg::byte_count_t'(1) && out_ready);
  assign load       = s1_valid && queue_free;
  assign in_ready   = !s1_valid || load;

  assign out_item.out_byte = queue[0];
  assign out_item.last     = (count == smfenc_pkg::byte_count_t'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smfenc_pkg::STATE_RESET;
    end else if (load) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= exp_count;
    end else if (pop) begin
      count <= count - smfenc_pkg::byte_count_t'(1);
    end
  end

  // The queue shifts towards entry zero as bytes leave.
  always_ff @(posedge clk) begin
    if (load) begin
      queue <= exp_bytes;
    end else if (pop) begin
      queue <= queue >> 8;
    end
  end

  `SMF_ASSERT_SAME(a_load_only_when_free, clk, rst, load,
                   count == '0 || (count == smfenc_pkg::byte_count_t'(1) && out_ready))
  `SMF_ASSERT_SAME(a_count_in_range, clk, rst, 1'b1,
                   count <= smfenc_pkg::byte_count_t'(smfenc_pkg::MaxBytes))
  `SMF_ASSERT_SAME(a_ready_when_empty, clk, rst, !s1_valid, in_ready)
  `SMF_ASSERT_NEXT(a_no_gap_in_header, clk, rst,
                   pop && count > smfenc_pkg::byte_count_t'(1), out_valid)
  `SMF_ASSERT_NEXT(a_channel_header_expects_status, clk, rst,
                   load && s1_item.req_type == smfenc_pkg::REQ_HEADER
                   && s1_item.kind == smfenc_pkg::KIND_CHANNEL,
                   state.expect_first_byte)

endmodule

// ----- rtl/smfenc_expand.sv -----
// Expands one registered request into its list of track bytes and next state.
// Depends on smfenc_pkg.
module smfenc_expand (
  input  smfenc_pkg::in_item_t    item,
  input  smfenc_pkg::enc_state_t  state,
  output smfenc_pkg::byte_list_t  bytes,
  output smfenc_pkg::byte_count_t count,
  output smfenc_pkg::enc_state_t  state_next
);

  logic [31:0]      diff;
  logic [27:0]      delta;
  logic [7:0]       type_byte;
  smfenc_pkg::vlq_t delta_vlq;
  smfenc_pkg::vlq_t len_vlq;
  logic [3:0]       pos;

  // Negative or zero differences give zero; large ones saturate to 28 bits.
  assign diff = item.tick - state.previous_tick;
  always_comb begin
    if (diff[31] || diff == '0) begin
      delta = '0;
    end else if (diff[30:28] != '0) begin
      delta = '1;
    end else begin
      delta = diff[27:0];
    end
  end

  assign delta_vlq = smfenc_pkg::vlq_encode(delta);
  assign len_vlq   = smfenc_pkg::vlq_encode(item.event_length);

  always_comb begin
    case (item.kind)
      smfenc_pkg::KIND_META:  type_byte = smfenc_pkg::TYPE_META;
      smfenc_pkg::KIND_SYSEX: type_byte = smfenc_pkg::TYPE_SYSEX;
      default:                type_byte = smfenc_pkg::TYPE_ESCAPE;
    endcase
  end

  always_comb begin
    bytes      = '0;
    pos        = '0;
    state_next = state;
    case (item.req_type)
      smfenc_pkg::REQ_START: begin
        state_next = smfenc_pkg::STATE_RESET;
      end
      smfenc_pkg::REQ_HEADER: begin
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < delta_vlq.count) begin
            bytes[i] = delta_vlq.bytes[i];
          end
        end
        pos = {1'b0, delta_vlq.count};
        state_next.previous_tick = item.tick;
        state_next.current_kind  = item.kind;
        if (item.kind == smfenc_pkg::KIND_CHANNEL) begin
          state_next.expect_first_byte = 1'b1;
        end else begin
          state_next.expect_first_byte = 1'b0;
          state_next.running_status    = type_byte;
          bytes[pos] = type_byte;
          pos = pos + 4'd1;
          if (item.kind == smfenc_pkg::KIND_META) begin
            bytes[pos] = item.meta_type;
            pos = pos + 4'd1;
          end
          for (int i = 0; i < 4; i++) begin
            if (3'(i) < len_vlq.count) begin
              bytes[pos + 4'(i)] = len_vlq.bytes[i];
            end
          end
          pos = pos + {1'b0, len_vlq.count};
        end
      end
      smfenc_pkg::REQ_DATA: begin
        bytes[0] = item.data_byte;
        pos      = 4'd1;
        // The first byte after a channel header is its status byte.
        if (state.current_kind == smfenc_pkg::KIND_CHANNEL && state.expect_first_byte) begin
          state_next.expect_first_byte = 1'b0;
          if (item.data_byte == state.running_status) begin
            pos = '0;
          end else begin
            state_next.running_status = item.data_byte;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign count = smfenc_pkg::byte_count_t'(pos);

endmodule

// ----- sim/smf_stream_checker.sv -----
// Scoreboard for the SMF track event encoder: watches both channels, predicts
// the track byte stream from each accepted request and compares it beat by beat.
// Depends on smfenc_pkg for the channel payload types and the request and kind codes.
`timescale 1ns / 100ps

module smf_stream_checker
  import smfenc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        fail_count,
  output int        bytes_pending
);

  // Encoder state as the predictor sees it.
  logic [7:0]  status_byte;
  logic [31:0] last_tick;
  logic [1:0]  event_kind;
  logic        await_status;

  out_item_t track_bytes[$];
  int        errors = 0;

  initial begin
    fail_count    = 0;
    bytes_pending = 0;
  end

  function automatic void push_byte(input logic [7:0] b);
    out_item_t beat;
    beat.out_byte = b;
    beat.last     = 1'b0;
    track_bytes.push_back(beat);
  endfunction

  // Big-endian groups of seven bits, continuation bit on all but the final group.
  function automatic void push_vlq(input logic [27:0] v);
    int groups;
    groups = 1;
    if (v[27:7] != '0) groups = 2;
    if (v[27:14] != '0) groups = 3;
    if (v[27:21] != '0) groups = 4;
    for (int g = groups - 1; g >= 0; g--) begin
      push_byte({g != 0, v[7*g +: 7]});
    end
  endfunction

  function automatic void predict_track_bytes(input in_item_t it);
    logic [31:0] diff;
    logic [27:0] delta;
    logic [7:0]  type_byte;
    logic        emit;
    case (it.req_type)
      REQ_START: begin
        status_byte  = 8'h00;
        last_tick    = 32'h0;
        event_kind   = KIND_CHANNEL;
        await_status = 1'b0;
      end
      REQ_HEADER: begin
        diff = it.tick - last_tick;
        // A backwards or zero step gives delta zero; a huge step saturates.
        if (diff[31] || diff == 32'h0) begin
          delta = '0;
        end else if (diff > 32'h0FFF_FFFF) begin
          delta = '1;
        end else begin
          delta = diff[27:0];
        end
        last_tick  = it.tick;
        event_kind = it.kind;
        push_vlq(delta);
        if (it.kind == KIND_CHANNEL) begin
          await_status = 1'b1;
        end else begin
          case (it.kind)
            KIND_META:  type_byte = TYPE_META;
            KIND_SYSEX: type_byte = TYPE_SYSEX;
            default:    type_byte = TYPE_ESCAPE;
          endcase
          await_status = 1'b0;
          push_byte(type_byte);
          if (it.kind == KIND_META) push_byte(it.meta_type);
          push_vlq(it.event_length);
          status_byte = type_byte;
        end
        track_bytes[track_bytes.size() - 1].last = 1'b1;
      end
      REQ_DATA: begin
        emit = 1'b1;
        if (event_kind == KIND_CHANNEL && await_status) begin
          await_status = 1'b0;
          // A status byte that repeats the running status is left out.
          if (it.data_byte == status_byte) begin
            emit = 1'b0;
          end else begin
            status_byte = it.data_byte;
          end
        end
        if (emit) begin
          push_byte(it.data_byte);
          track_bytes[track_bytes.size() - 1].last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      status_byte  = 8'h00;
      last_tick    = 32'h0;
      event_kind   = KIND_CHANNEL;
      await_status = 1'b0;
      track_bytes.delete();
    end else begin
      // Results pass through the input register and then the byte queue, so the output
      // beat of this edge never belongs to the request accepted at the same edge.
      if (out_valid && out_ready) begin
        if (track_bytes.size() == 0) begin
          $error("out_item: unexpected beat, out_byte %h last %b",
                 out_item.out_byte, out_item.last);
          errors++;
        end else begin
          want = track_bytes.pop_front();
          if (out_item.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_item.out_byte);
            errors++;
          end
          if (out_item.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_item.last);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) predict_track_bytes(in_item);
    end
    fail_count    <= errors;
    bytes_pending <= track_bytes.size();
  end

endmodule

// ----- sim/smf_track_event_encoder_test.sv -----
// Testbench top for the SMF track event encoder: clock, reset, request stimulus
// in bursts, a stalling receiver and the verdict.
// Depends on smfenc_pkg, smf_stream_checker and the encoder RTL.
`timescale 1ns / 100ps

module smf_track_event_encoder_test;
  import smfenc_pkg::*;

  // The fourth request code, which the block ignores.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int HoldCycles = 400;
  localparam int HoldAfterBeats = 150;
  localparam int TargetBeats = 320;

  typedef enum int {RX_FREE, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        bytes_pending;

  int          beats_sent = 0;
  int          burst_left = 0;
  logic [31:0] tick_now = 32'h0;

  smf_track_event_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  smf_stream_checker i_stream_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .bytes_pending (bytes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic in_item_t make_item(input logic [1:0] req, input logic [31:0] tick,
                                         input logic [1:0] kind, input logic [7:0] mtype,
                                         input logic [27:0] len, input logic [7:0] db);
    in_item_t it;
    it.req_type     = req;
    it.tick         = tick;
    it.kind         = kind;
    it.meta_type    = mtype;
    it.event_length = len;
    it.data_byte    = db;
    return it;
  endfunction

  // Offers one beat and returns once it has been taken; gaps fall between bursts.
  task automatic send(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.req_type == REQ_HEADER || it.req_type == REQ_DATA) beats_sent++;
  endtask

  function automatic logic [31:0] next_tick();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return tick_now + $urandom_range(0, 127);
    if (roll < 75) return tick_now + $urandom_range(128, 20000);
    if (roll < 85) return tick_now + $urandom_range(0, 1 << 22);
    if (roll < 90) return tick_now;
    if (roll < 95) return tick_now - $urandom_range(1, 1000);
    return $urandom;
  endfunction

  task automatic send_data(input logic [7:0] db);
    send(make_item(REQ_DATA, $urandom, 2'($urandom), 8'($urandom), 28'($urandom), db));
  endtask

  // One well-formed event with random content, now and then cut short.
  task automatic send_event();
    int          roll;
    int          n;
    logic [7:0]  status;
    logic [27:0] len;
    logic [1:0]  kind;
    roll     = $urandom_range(0, 99);
    tick_now = next_tick();
    if (roll < 60) begin
      send(make_item(REQ_HEADER, tick_now, KIND_CHANNEL, 8'($urandom), 28'($urandom),
                     8'($urandom)));
      case ($urandom_range(0, 3))
        0:       status = 8'h90;
        1:       status = 8'h80;
        2:       status = 8'hB0;
        default: status = {4'h8 + 4'($urandom_range(0, 6)), 4'($urandom_range(0, 15))};
      endcase
      if ($urandom_range(0, 9) != 0) send_data(status);
      n = $urandom_range(0, 2);
      repeat (n) send_data(8'($urandom_range(0, 127)));
    end else begin
      if (roll < 80) begin
        kind = KIND_META;
      end else begin
        kind = $urandom_range(0, 1) ? KIND_SYSEX : KIND_ESCAPE;
      end
      len = ($urandom_range(0, 9) == 0) ? 28'($urandom) : 28'($urandom_range(0, 4));
      send(make_item(REQ_HEADER, tick_now, kind, 8'($urandom), len, 8'($urandom)));
      n = (len > 4) ? $urandom_range(0, 4) : int'(len);
      repeat (n) send_data(8'($urandom));
    end
  endtask

  task automatic send_noise();
    logic [95:0] raw;
    in_item_t    it;
    raw = {$urandom, $urandom, $urandom};
    it  = raw[79:0];
    if (it.req_type == REQ_START) tick_now = 32'h0;
    send(it);
  endtask

  // Receiver: random stall patterns, plus one long hold-off once traffic is flowing.
  initial begin : receiver
    rx_mode_t mode;
    int       stretch;
    int       hold;
    bit       held;
    mode    = RX_FREE;
    stretch = 0;
    hold    = 0;
    held    = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && beats_sent >= HoldAfterBeats) begin
        held = 1'b1;
        hold = HoldCycles;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          mode    = rx_mode_t'($urandom_range(0, 3));
          stretch = $urandom_range(16, 96);
        end
        stretch--;
        case (mode)
          RX_FREE:   out_ready <= 1'b1;
          RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int roll;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: delta sizes, dropped status bytes, negative and saturated deltas,
    // the longest header, data before any header and the unused request code.
    send(make_item(REQ_START, '0, KIND_CHANNEL, '0, '0, '0));
    send_data(8'h45);
    send(make_item(REQ_HEADER, 32'h0, KIND_CHANNEL, '0, '0, '0));
    send_data(8'h90);
    send_data(8'h3C);
    send(make_item(REQ_HEADER, 32'h7F, KIND_CHANNEL, '0, '0, '0));
    send_data(8'h90);
    send_data(8'h40);
    send(make_item(REQ_HEADER, 32'h80, KIND_META, 8'h51, 28'h0, '0));
    send(make_item(REQ_HEADER, 32'h80, KIND_CHANNEL, '0, '0, '0));
    send_data(8'hFF);
    send(make_item(REQ_HEADER, 32'h4080, KIND_SYSEX, '0, 28'h7F, '0));
    send(make_item(REQ_HEADER, 32'h20_4080, KIND_ESCAPE, '0, 28'h80, '0));
    send(make_item(REQ_HEADER, 32'h10, KIND_META, 8'hFF, 28'hFFF_FFFF, '0));
    send(make_item(REQ_HEADER, 32'h7FFF_FFFF, KIND_META, 8'h00, 28'h20_0000, '0));
    send(make_item(REQ_HEADER, 32'hFFFF_FFFF, KIND_CHANNEL, '0, '0, '0));
    send_data(8'h00);
    send_data(8'hFF);
    send(make_item(REQ_UNUSED, '1, KIND_ESCAPE, '1, '1, '1));
    send(make_item(REQ_START, '1, KIND_ESCAPE, '1, '1, '1));
    send(make_item(REQ_HEADER, 32'h0, KIND_CHANNEL, '0, '0, '0));
    send_data(8'h00);
    send_data(8'h7F);
    tick_now = 32'h0;

    while (beats_sent < TargetBeats) begin
      roll = $urandom_range(0, 99);
      if (roll < 72) begin
        send_event();
      end else if (roll < 77) begin
        tick_now = 32'h0;
        send(make_item(REQ_START, $urandom, 2'($urandom), 8'($urandom), 28'($urandom),
                       8'($urandom)));
      end else begin
        send_noise();
      end
    end

    in_valid <= 1'b0;
    // The checker's pending count is registered, so it lags the final request.
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && bytes_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/smfenc_pkg.sv
rtl/smfenc_expand.sv
rtl/smf_track_event_encoder.sv
sim/smf_stream_checker.sv
sim/smf_track_event_encoder_test.sv
